FILE: hw/rtl/mcpm_pkg.sv
// Package for the multi-channel pulse modulator.
// Holds the transaction types, the command and channel record types and
// the function codes. No dependencies.
package mcpm_pkg;

  // Input function codes
  localparam logic [1:0] FUNC_TICK  = 2'd0;
  localparam logic [1:0] FUNC_CLEAR = 2'd1;
  localparam logic [1:0] FUNC_SET   = 2'd2;

  // Drive kinds on the result side
  localparam logic DRIVE_DIGITAL = 1'b0;
  localparam logic DRIVE_ANALOG  = 1'b1;

  // Queue depths (powers of two)
  localparam int unsigned CMD_DEPTH = 2;
  localparam int unsigned RES_DEPTH = 4;

  typedef enum logic [1:0] {
    CMD_TICK,
    CMD_CLEAR,
    CMD_SET
  } cmd_kind_e;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_RUN,
    BK_FLUSH
  } back_state_e;

  typedef struct packed {
    logic [1:0]         func;
    logic [7:0]         channel;
    logic signed [7:0]  pin;
    logic signed [31:0] drive_level;
    logic [31:0]        low_time;
    logic [31:0]        on_time;
    logic               pin_sample;
  } in_item_t;

  typedef struct packed {
    logic [5:0]         out_channel;
    logic signed [7:0]  out_pin;
    logic               drive_kind;
    logic signed [31:0] drive_value;
    logic               last;
  } out_item_t;

  // Classified command handed from front to back
  typedef struct packed {
    cmd_kind_e         kind;
    logic [7:0]        channel;
    logic signed [7:0] pin;
    logic [31:0]       value;
    logic [31:0]       low_time;
    logic [31:0]       on_time;
    logic              sample;
    logic              is_dig;
    logic              is_ana;
  } cmd_t;

  // One channel as kept in the channel memory
  typedef struct packed {
    logic signed [7:0] pin;
    logic [31:0]       value;
    logic [31:0]       low_time;
    logic [31:0]       on_time;
    logic [31:0]       stamp;
    logic              high;
  } chan_rec_t;

  localparam chan_rec_t CHAN_RESET = '{
    pin:      8'hFF,
    value:    32'd0,
    low_time: 32'd0,
    on_time:  32'd0,
    stamp:    32'd0,
    high:     1'b0
  };

endpackage

FILE: hw/rtl/mcpm_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module mcpm_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                   clk_i,
  input  logic                   we_i,
  input  logic [AddrW-1:0]       waddr_i,
  input  logic [WIDTH-1:0]       wdata_i,
  input  logic                   re_i,
  input  logic [AddrW-1:0]       raddr_i,
  output logic [WIDTH-1:0]       rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hw/rtl/mcpm_fifo.sv
// Small synchronous FIFO on flip-flops, head visible while not empty.
// DEPTH must be a power of two, at least 2. No dependencies.
module mcpm_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             empty_o
);
  localparam int unsigned AW = $clog2(DEPTH);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [AW-1:0]    wptr_q, wptr_d, rptr_q, rptr_d;
  logic [AW:0]      cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == (AW+1)'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rptr_q];

  always_comb begin
    wptr_d = do_push ? wptr_q + 1'b1 : wptr_q;
    rptr_d = do_pop ? rptr_q + 1'b1 : rptr_q;
    cnt_d  = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= data_i;
    end
  end

endmodule

FILE: hw/rtl/mcpm_front.sv
// Front end: accepts input transactions, decodes the function, range-checks
// the channel and classifies the pin. Depends on mcpm_pkg.
module mcpm_front import mcpm_pkg::*; #(
  parameter int NUM_CHANNELS = 64,
  parameter int ANALOG_FIRST = 54,
  parameter int ANALOG_LAST  = 69
) (
  input  in_item_t in_item_i,
  input  logic     push,
  output logic     full,
  input  logic     cmd_full_i,
  output logic     cmd_push_o,
  output cmd_t     cmd_o
);
  logic keep;
  logic in_range;

  assign full     = cmd_full_i;
  assign in_range = ({24'd0, in_item_i.channel} < 32'(NUM_CHANNELS));

  always_comb begin
    cmd_o.channel  = in_item_i.channel;
    cmd_o.pin      = in_item_i.pin;
    cmd_o.value    = in_item_i.drive_level;
    cmd_o.low_time = in_item_i.low_time;
    cmd_o.on_time  = in_item_i.on_time;
    cmd_o.sample   = in_item_i.pin_sample;
    cmd_o.is_dig   = (in_item_i.pin >= 0) && (in_item_i.pin < ANALOG_FIRST);
    cmd_o.is_ana   = (in_item_i.pin >= ANALOG_FIRST) && (in_item_i.pin <= ANALOG_LAST);
    cmd_o.kind     = CMD_TICK;
    keep           = 1'b0;
    unique case (in_item_i.func)
      FUNC_TICK: begin
        cmd_o.kind = CMD_TICK;
        keep       = 1'b1;
      end
      FUNC_CLEAR: begin
        cmd_o.kind = CMD_CLEAR;
        keep       = 1'b1;
      end
      FUNC_SET: begin
        cmd_o.kind = CMD_SET;
        keep       = in_range;
      end
      default: begin
        keep = 1'b0;  // undefined function, dropped
      end
    endcase
  end

  assign cmd_push_o = push && !cmd_full_i && keep;

endmodule

FILE: hw/rtl/mcpm_back.sv
// Back end: executes commands against the channel memory, one channel per
// cycle unless a full result queue holds it up, and hands drive changes to
// the result queue. Depends on mcpm_pkg and mcpm_ram.
module mcpm_back import mcpm_pkg::*; #(
  parameter int NUM_CHANNELS = 64,
  parameter int ANALOG_FIRST = 54
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cmd_t      cmd_i,
  input  logic      cmd_empty_i,
  output logic      cmd_pop_o,
  output out_item_t res_o,
  output logic      res_push_o,
  input  logic      res_full_i
);
  localparam int unsigned IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam logic [IDX_W-1:0] LastIdx = IDX_W'(NUM_CHANNELS - 1);
  localparam int unsigned RecW = $bits(chan_rec_t);

  back_state_e state_q, state_d;
  cmd_t        cur_q, cur_d;
  logic [31:0] now_q, now_d;
  logic [NUM_CHANNELS-1:0] vld_q, vld_d;
  logic [IDX_W-1:0] rd_idx_q, rd_idx_d, b_idx_q, b_idx_d;
  logic        pend_q, pend_d, b_vld_q, b_vld_d, h_vld_q, h_vld_d;
  out_item_t   h_q, h_d;

  logic            ram_we, ram_re;
  logic [RecW-1:0] ram_rdata;
  chan_rec_t       rec_cur, rec_new;
  out_item_t       res_new;
  logic            produce, advance, last_issue;
  logic [31:0]     elapsed;
  logic            analog;
  logic [7:0]      ch8;

  mcpm_ram #(
    .WIDTH(RecW),
    .DEPTH(NUM_CHANNELS)
  ) u_chan_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(b_idx_q),
    .wdata_i(rec_new),
    .re_i   (ram_re),
    .raddr_i(rd_idx_q),
    .rdata_o(ram_rdata)
  );

  // A channel never written since reset or clear reads as its reset record
  assign rec_cur = vld_q[b_idx_q] ? chan_rec_t'(ram_rdata) : CHAN_RESET;
  assign elapsed = now_q - rec_cur.stamp;
  assign analog  = (rec_cur.pin >= ANALOG_FIRST);
  assign ch8     = 8'(b_idx_q);

  // Channel update for the entry in the second stage
  always_comb begin
    rec_new = rec_cur;
    produce = 1'b0;
    res_new = '0;
    if (cur_q.kind == CMD_SET) begin
      rec_new.pin      = cur_q.pin;
      rec_new.value    = cur_q.value;
      rec_new.low_time = cur_q.low_time;
      rec_new.on_time  = cur_q.on_time;
      if (cur_q.is_dig) begin
        res_new.drive_kind = DRIVE_DIGITAL;
        if (cur_q.sample && cur_q.value == 32'd0) begin
          produce             = 1'b1;
          res_new.drive_value = 32'sd0;
          rec_new.stamp       = 32'd0;
        end else if (!cur_q.sample && cur_q.value == 32'd1) begin
          produce             = 1'b1;
          res_new.drive_value = 32'sd1;
          rec_new.stamp       = 32'd0;
        end
      end else if (cur_q.is_ana) begin
        produce             = 1'b1;
        res_new.drive_kind  = DRIVE_ANALOG;
        res_new.drive_value = cur_q.value;
      end
    end else if (rec_cur.value != 32'd0 && !rec_cur.value[31] &&
                 (rec_cur.low_time != 32'd0 || rec_cur.on_time != 32'd0)) begin
      res_new.drive_kind = analog ? DRIVE_ANALOG : DRIVE_DIGITAL;
      if (!rec_cur.high) begin
        if (elapsed >= rec_cur.low_time) begin
          produce             = 1'b1;
          res_new.drive_value = analog ? rec_cur.value : 32'sd1;
          rec_new.stamp       = now_q;
          rec_new.high        = 1'b1;
        end
      end else if (rec_cur.on_time == 32'd0) begin
        // one-shot: high phase over, value dropped
        if (elapsed >= rec_cur.low_time) begin
          produce             = 1'b1;
          res_new.drive_value = 32'sd0;
          rec_new.stamp       = now_q;
          rec_new.high        = 1'b0;
          rec_new.value       = 32'd0;
        end
      end else if (elapsed >= rec_cur.on_time) begin
        produce             = 1'b1;
        res_new.drive_value = 32'sd0;
        rec_new.stamp       = now_q;
        rec_new.high        = 1'b0;
      end
    end
    res_new.out_channel = ch8[5:0];
    res_new.out_pin     = rec_new.pin;
    res_new.last        = 1'b0;
  end

  // The held result goes out only once a later one exists or the walk ends,
  // so its last flag is known.
  assign advance    = !(b_vld_q && produce && h_vld_q && res_full_i);
  assign last_issue = (cur_q.kind == CMD_SET) || (rd_idx_q == LastIdx);

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      BK_IDLE: begin
        if (!cmd_empty_i && cmd_i.kind != CMD_CLEAR) begin
          state_d = BK_RUN;
        end
      end
      BK_RUN: begin
        if (!pend_q && !b_vld_q) begin
          state_d = BK_FLUSH;
        end
      end
      BK_FLUSH: begin
        if (!h_vld_q || !res_full_i) begin
          state_d = BK_IDLE;
        end
      end
      default: state_d = BK_IDLE;
    endcase
  end

  // Outputs and datapath
  always_comb begin
    cur_d      = cur_q;
    now_d      = now_q;
    vld_d      = vld_q;
    rd_idx_d   = rd_idx_q;
    pend_d     = pend_q;
    b_vld_d    = b_vld_q;
    b_idx_d    = b_idx_q;
    h_vld_d    = h_vld_q;
    h_d        = h_q;
    cmd_pop_o  = 1'b0;
    ram_we     = 1'b0;
    ram_re     = 1'b0;
    res_push_o = 1'b0;
    res_o      = h_q;
    unique case (state_q)
      BK_IDLE: begin
        if (!cmd_empty_i) begin
          cmd_pop_o = 1'b1;
          cur_d     = cmd_i;
          pend_d    = 1'b1;
          unique case (cmd_i.kind)
            CMD_CLEAR: begin
              vld_d  = '0;
              pend_d = 1'b0;
            end
            CMD_TICK: begin
              now_d    = now_q + 32'd1;
              rd_idx_d = '0;
            end
            CMD_SET: begin
              rd_idx_d = cmd_i.channel[IDX_W-1:0];
            end
            default: pend_d = 1'b0;
          endcase
        end
      end
      BK_RUN: begin
        if (advance) begin
          if (pend_q) begin
            ram_re   = 1'b1;
            b_vld_d  = 1'b1;
            b_idx_d  = rd_idx_q;
            rd_idx_d = rd_idx_q + 1'b1;
            pend_d   = !last_issue;
          end else begin
            b_vld_d = 1'b0;
          end
          if (b_vld_q) begin
            ram_we         = 1'b1;
            vld_d[b_idx_q] = 1'b1;
            if (produce) begin
              res_push_o = h_vld_q;
              h_d        = res_new;
              h_vld_d    = 1'b1;
            end
          end
        end
      end
      BK_FLUSH: begin
        res_o.last = 1'b1;
        if (h_vld_q && !res_full_i) begin
          res_push_o = 1'b1;
          h_vld_d    = 1'b0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= BK_IDLE;
      now_q    <= '0;
      vld_q    <= '0;
      rd_idx_q <= '0;
      pend_q   <= 1'b0;
      b_vld_q  <= 1'b0;
      b_idx_q  <= '0;
      h_vld_q  <= 1'b0;
    end else begin
      state_q  <= state_d;
      now_q    <= now_d;
      vld_q    <= vld_d;
      rd_idx_q <= rd_idx_d;
      pend_q   <= pend_d;
      b_vld_q  <= b_vld_d;
      b_idx_q  <= b_idx_d;
      h_vld_q  <= h_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;
    h_q   <= h_d;
  end

  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_push_o |-> !res_full_i)
    else $error("result pushed into a full queue");

  a_write_in_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (state_q == BK_RUN))
    else $error("channel write outside a walk");

  a_stage_in_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (b_vld_q || pend_q) |-> (state_q == BK_RUN))
    else $error("walk stage busy outside a walk");

  a_flush_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == BK_FLUSH && state_d == BK_IDLE) |=> !h_vld_q)
    else $error("held result left after item end");

  a_idle_no_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == BK_IDLE) |-> !h_vld_q)
    else $error("held result while idle");

endmodule

FILE: hw/rtl/multi_channel_pulse_modulator_top.sv
// Top level of the multi-channel pulse modulator: front end, command queue,
// back end with channel memory, result queue.
// Depends on mcpm_pkg, mcpm_fifo, mcpm_front, mcpm_back.
//
// Usage:
//   Input channel: drive in_item_i and raise push; the transaction is taken
//   at an edge with push high and full low. Functions: tick (advance the
//   microsecond counter and walk all channels), clear (reset all channels),
//   set (store one channel and drive it at once). Undefined functions and
//   sets to channels beyond NUM_CHANNELS are dropped.
//   Result channel: while empty is low, out_item_o holds the oldest drive
//   change; raise pop to take it. The last result of a transaction has last=1.
//   Throughput: a tick walks the channel memory (one write port, one read
//   port) at one channel per cycle while the result queue has room; a set
//   visits its own channel only, a clear none. The back end takes no new
//   command from the command queue until it is through with the last one.
//   A stalled receiver holds up the walk once the result queue is full; the
//   command queue keeps taking transactions until it too is full.
//   Reset clears all channels and the microsecond counter.
module multi_channel_pulse_modulator_top import mcpm_pkg::*; #(
  parameter int NUM_CHANNELS = 64,
  parameter int ANALOG_FIRST = 54,
  parameter int ANALOG_LAST  = 69
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  in_item_t  in_item_i,
  input  logic      push,
  output logic      full,
  output out_item_t out_item_o,
  output logic      empty,
  input  logic      pop
);
  localparam int unsigned CmdW = $bits(cmd_t);
  localparam int unsigned ResW = $bits(out_item_t);

  cmd_t            cmd_in, cmd_head;
  logic            cmd_push, cmd_full, cmd_pop, cmd_empty;
  logic [CmdW-1:0] cmd_head_bits;
  out_item_t       res_in;
  logic            res_push, res_full;
  logic [ResW-1:0] res_head_bits;

  mcpm_front #(
    .NUM_CHANNELS(NUM_CHANNELS),
    .ANALOG_FIRST(ANALOG_FIRST),
    .ANALOG_LAST (ANALOG_LAST)
  ) u_front (
    .in_item_i (in_item_i),
    .push      (push),
    .full      (full),
    .cmd_full_i(cmd_full),
    .cmd_push_o(cmd_push),
    .cmd_o     (cmd_in)
  );

  mcpm_fifo #(
    .WIDTH(CmdW),
    .DEPTH(CMD_DEPTH)
  ) u_cmd_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (cmd_push),
    .data_i (cmd_in),
    .full_o (cmd_full),
    .pop_i  (cmd_pop),
    .data_o (cmd_head_bits),
    .empty_o(cmd_empty)
  );

  assign cmd_head = cmd_t'(cmd_head_bits);

  mcpm_back #(
    .NUM_CHANNELS(NUM_CHANNELS),
    .ANALOG_FIRST(ANALOG_FIRST)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd_head),
    .cmd_empty_i(cmd_empty),
    .cmd_pop_o  (cmd_pop),
    .res_o      (res_in),
    .res_push_o (res_push),
    .res_full_i (res_full)
  );

  mcpm_fifo #(
    .WIDTH(ResW),
    .DEPTH(RES_DEPTH)
  ) u_res_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (res_push),
    .data_i (res_in),
    .full_o (res_full),
    .pop_i  (pop),
    .data_o (res_head_bits),
    .empty_o(empty)
  );

  assign out_item_o = out_item_t'(res_head_bits);

endmodule

FILE: tb/mcpm_drive_checker.sv
`timescale 1ns / 100ps
// Scoreboard for the multi-channel pulse modulator: watches both queue ports,
// predicts the drive changes of every accepted transaction and compares them.
// Depends on mcpm_pkg.
module mcpm_drive_checker import mcpm_pkg::*; #(
  parameter int NUM_CH    = 64,
  parameter int ANA_FIRST = 54,
  parameter int ANA_LAST  = 69
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  in_item_t  in_item_i,
  input  logic      push_i,
  input  logic      full_i,
  input  out_item_t out_item_i,
  input  logic      empty_i,
  input  logic      pop_i,
  output int        fail_count_o,
  output int        pending_o,
  output int        checked_o,
  output int        analog_seen_o
);

  logic signed [7:0] pin_q   [NUM_CH];
  logic [31:0]       level_q [NUM_CH];
  logic [31:0]       off_q   [NUM_CH];
  logic [31:0]       on_q    [NUM_CH];
  logic [31:0]       stamp_q [NUM_CH];
  logic              high_q  [NUM_CH];
  logic [31:0]       us_q;

  out_item_t expected_drives[$];
  out_item_t exp_d;

  function automatic out_item_t drive_of(int idx, logic kind, logic [31:0] val);
    out_item_t r;
    r.out_channel = 6'(idx);
    r.out_pin     = pin_q[idx];
    r.drive_kind  = kind;
    r.drive_value = val;
    r.last        = 1'b0;
    return r;
  endfunction

  task automatic clear_channels();
    for (int i = 0; i < NUM_CH; i++) begin
      pin_q[i]   = -8'sd1;
      level_q[i] = '0;
      off_q[i]   = '0;
      on_q[i]    = '0;
      stamp_q[i] = '0;
      high_q[i]  = 1'b0;
    end
  endtask

  task automatic predict_drives(in_item_t it);
    out_item_t   batch[$];
    int          c;
    logic [31:0] v;
    logic [31:0] el;
    logic        ana;
    case (it.func)
      FUNC_CLEAR: clear_channels();
      FUNC_SET: begin
        if (it.channel < NUM_CH) begin
          c = int'(it.channel);
          pin_q[c]   = it.pin;
          level_q[c] = it.drive_level;
          off_q[c]   = it.low_time;
          on_q[c]    = it.on_time;
          if (it.pin >= 0 && it.pin < ANA_FIRST) begin
            // digital pin only driven when the sampled level disagrees
            if (it.pin_sample && it.drive_level == 0) begin
              batch.push_back(drive_of(c, DRIVE_DIGITAL, 32'd0));
              stamp_q[c] = '0;
            end else if (!it.pin_sample && it.drive_level == 1) begin
              batch.push_back(drive_of(c, DRIVE_DIGITAL, 32'd1));
              stamp_q[c] = '0;
            end
          end else if (it.pin >= ANA_FIRST && it.pin <= ANA_LAST) begin
            batch.push_back(drive_of(c, DRIVE_ANALOG, it.drive_level));
          end
        end
      end
      FUNC_TICK: begin
        us_q = us_q + 32'd1;
        for (int i = 0; i < NUM_CH; i++) begin
          v = level_q[i];
          if (v != 0 && !v[31] && (off_q[i] != 0 || on_q[i] != 0)) begin
            el  = us_q - stamp_q[i];
            // pins above the analog range still get duty writes on a tick
            ana = (pin_q[i] >= ANA_FIRST);
            if (!high_q[i]) begin
              if (el >= off_q[i]) begin
                batch.push_back(drive_of(i, ana ? DRIVE_ANALOG : DRIVE_DIGITAL,
                                         ana ? v : 32'd1));
                stamp_q[i] = us_q;
                high_q[i]  = 1'b1;
              end
            end else if (on_q[i] == 0) begin
              // one-shot: high for the low time, then the value is dropped
              if (el >= off_q[i]) begin
                batch.push_back(drive_of(i, ana ? DRIVE_ANALOG : DRIVE_DIGITAL, 32'd0));
                stamp_q[i] = us_q;
                high_q[i]  = 1'b0;
                level_q[i] = '0;
              end
            end else if (el >= on_q[i]) begin
              batch.push_back(drive_of(i, ana ? DRIVE_ANALOG : DRIVE_DIGITAL, 32'd0));
              stamp_q[i] = us_q;
              high_q[i]  = 1'b0;
            end
          end
        end
      end
      default: ;
    endcase
    if (batch.size() > 0) batch[batch.size() - 1].last = 1'b1;
    foreach (batch[k]) expected_drives.push_back(batch[k]);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_channels();
      us_q = '0;
      expected_drives.delete();
      pending_o     = 0;
      fail_count_o  = 0;
      checked_o     = 0;
      analog_seen_o = 0;
    end else begin
      // results first: a transaction taken at this edge cannot have produced one yet
      if (pop_i && !empty_i) begin
        checked_o++;
        if (out_item_i.drive_kind == DRIVE_ANALOG) analog_seen_o++;
        if (expected_drives.size() == 0) begin
          fail_count_o++;
          if (fail_count_o <= 10)
            $display("%0t unexpected drive: ch=%0d pin=%0d kind=%0d val=%0d last=%0d",
                     $realtime, out_item_i.out_channel, out_item_i.out_pin,
                     out_item_i.drive_kind, out_item_i.drive_value, out_item_i.last);
        end else begin
          exp_d = expected_drives.pop_front();
          if (exp_d !== out_item_i) begin
            fail_count_o++;
            if (fail_count_o <= 10) begin
              $write("%0t drive mismatch: exp ch=%0d pin=%0d kind=%0d val=%0d last=%0d",
                     $realtime, exp_d.out_channel, exp_d.out_pin, exp_d.drive_kind,
                     exp_d.drive_value, exp_d.last);
              $display(" / got ch=%0d pin=%0d kind=%0d val=%0d last=%0d",
                       out_item_i.out_channel, out_item_i.out_pin,
                       out_item_i.drive_kind, out_item_i.drive_value,
                       out_item_i.last);
            end
          end
        end
      end
      if (push_i && !full_i) predict_drives(in_item_i);
      pending_o = expected_drives.size();
    end
  end

endmodule

FILE: tb/tb_multi_channel_pulse_modulator_top.sv
`timescale 1ns / 100ps
// Testbench top for the multi-channel pulse modulator: clock, reset, bursty
// stimulus, a stalling result receiver, watchdog and verdict.
// Depends on mcpm_pkg, multi_channel_pulse_modulator_top and mcpm_drive_checker.
module tb_multi_channel_pulse_modulator_top;
  import mcpm_pkg::*;

  localparam int NUM_CH    = 64;
  localparam int ANA_FIRST = 54;
  localparam int ANA_LAST  = 69;

  localparam logic [1:0] FUNC_UNUSED = 2'd3;

  localparam int TOTAL_ITEMS = 460;
  // a tick walk plus the longest receiver stall and sender gap, many times over
  localparam int IDLE_LIMIT  = 4000;
  localparam int TAIL_CYCLES = 3 * (NUM_CH + 4) + 20;

  logic      clk   = 1'b0;
  logic      rst_n = 1'b0;
  in_item_t  in_item = '0;
  logic      push  = 1'b0;
  logic      full;
  out_item_t out_item;
  logic      empty;
  logic      pop   = 1'b0;

  int fail_count;
  int pending;
  int checked;
  int analog_seen;

  int idle_cycles = 0;
  int burst_left  = 0;
  int items_sent  = 0;
  int ticks_sent  = 0;
  int rx_cycle    = 0;
  int stall_left  = 0;
  int stall_pct;
  int stall_max;
  bit mid_pause_done = 1'b0;

  always #10 clk = ~clk;

  multi_channel_pulse_modulator_top #(
    .NUM_CHANNELS (NUM_CH),
    .ANALOG_FIRST (ANA_FIRST),
    .ANALOG_LAST  (ANA_LAST)
  ) DUT (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_item_i  (in_item),
    .push       (push),
    .full       (full),
    .out_item_o (out_item),
    .empty      (empty),
    .pop        (pop)
  );

  mcpm_drive_checker #(
    .NUM_CH    (NUM_CH),
    .ANA_FIRST (ANA_FIRST),
    .ANA_LAST  (ANA_LAST)
  ) u_checker (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_item_i     (in_item),
    .push_i        (push),
    .full_i        (full),
    .out_item_i    (out_item),
    .empty_i       (empty),
    .pop_i         (pop),
    .fail_count_o  (fail_count),
    .pending_o     (pending),
    .checked_o     (checked),
    .analog_seen_o (analog_seen)
  );

  // watchdog: cycles in which neither side moves a transaction
  always @(posedge clk) begin
    if ((push && !full) || (pop && !empty)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
  end

  initial begin
    wait (idle_cycles >= IDLE_LIMIT);
    $display("multi_channel_pulse_modulator_top regression: fail");
    $finish;
  end

  // receiver: stall behavior steps through four settings in turn
  always @(negedge clk) begin
    case ((rx_cycle / 300) % 4)
      0: begin stall_pct = 0;  stall_max = 1;  end
      1: begin stall_pct = 20; stall_max = 3;  end
      2: begin stall_pct = 60; stall_max = 8;  end
      default: begin stall_pct = 5; stall_max = 40; end
    endcase
    if (!rst_n) begin
      pop <= 1'b0;
    end else if (stall_left > 0) begin
      pop <= 1'b0;
      stall_left--;
    end else begin
      pop <= 1'b1;
      if ($urandom_range(0, 99) < stall_pct) stall_left = $urandom_range(1, stall_max);
    end
    rx_cycle++;
  end

  function automatic in_item_t make_item(logic [1:0] func, logic [7:0] channel,
                                         logic signed [7:0] pin, logic [31:0] level,
                                         logic [31:0] off_t, logic [31:0] on_t,
                                         logic sample);
    in_item_t it;
    it.func        = func;
    it.channel     = channel;
    it.pin         = pin;
    it.drive_level = level;
    it.low_time    = off_t;
    it.on_time     = on_t;
    it.pin_sample  = sample;
    return it;
  endfunction

  // tick with junk in the fields it does not use
  function automatic in_item_t tick_item();
    return make_item(FUNC_TICK, 8'($urandom), 8'($urandom), $urandom, $urandom,
                     $urandom, 1'($urandom));
  endfunction

  function automatic logic signed [7:0] pick_pin();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return 8'($urandom_range(0, ANA_FIRST - 1));
      4, 5, 6:    return 8'($urandom_range(ANA_FIRST, ANA_LAST));
      7:          return 8'($urandom_range(ANA_LAST + 1, 127));
      8:          return -8'sd1;
      default:    return 8'($urandom);
    endcase
  endfunction

  // called at a falling edge; full only moves at rising edges, so its value
  // here is the one the next rising edge sees
  task automatic send(input in_item_t it);
    int gap;
    if (burst_left == 0) begin
      gap        = $urandom_range(0, 12);
      burst_left = $urandom_range(1, 16);
      if (gap > 0) begin
        push <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    in_item <= it;
    push    <= 1'b1;
    while (full) @(negedge clk);
    @(negedge clk);
    burst_left--;
    if (!(it.func == FUNC_UNUSED || (it.func == FUNC_SET && it.channel >= NUM_CH)))
      items_sent++;
    if (it.func == FUNC_TICK) ticks_sent++;
  endtask

  // sender holds off until every predicted drive change has been taken
  task automatic wait_drained();
    push <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
  endtask

  task automatic noise_item();
    send(make_item(2'($urandom_range(0, 3)), 8'($urandom), 8'($urandom), $urandom,
                   $urandom, $urandom, 1'($urandom)));
  endtask

  // program a few channels with short periods, then let time run
  task automatic run_pattern();
    logic [31:0] lvl;
    logic [31:0] off_t;
    logic [31:0] on_t;
    logic [7:0]  ch;
    if ($urandom_range(0, 3) == 0) send(make_item(FUNC_CLEAR, 0, 0, 0, 0, 0, 0));
    repeat ($urandom_range(1, 8)) begin
      case ($urandom_range(0, 3))
        0:       lvl = $urandom_range(0, 1);
        1:       lvl = 32'd1;
        2:       lvl = $urandom_range(2, 255);
        default: lvl = $urandom;
      endcase
      off_t = ($urandom_range(0, 15) == 0) ? $urandom : $urandom_range(0, 6);
      on_t  = ($urandom_range(0, 1) == 0) ? 32'd0 : $urandom_range(1, 6);
      if ($urandom_range(0, 15) == 0) on_t = $urandom;
      ch = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(NUM_CH, 255))
                                       : 8'($urandom_range(0, NUM_CH - 1));
      send(make_item(FUNC_SET, ch, pick_pin(), lvl, off_t, on_t, 1'($urandom)));
    end
    repeat ($urandom_range(4, 24)) begin
      if ($urandom_range(0, 19) == 0) noise_item();
      else send(tick_item());
    end
  endtask

  initial begin
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: pin classes, sample/value combinations, level and time extremes
    send(make_item(FUNC_TICK, 0, 0, 0, 0, 0, 0));
    send(make_item(FUNC_SET, 0, 8'sd0, 32'd1, 32'd3, 32'd2, 1'b0));
    send(make_item(FUNC_SET, 1, 8'sd53, 32'd0, 32'd1, 32'd1, 1'b1));
    send(make_item(FUNC_SET, 2, 8'sd10, 32'd1, 32'd2, 32'd1, 1'b1));
    send(make_item(FUNC_SET, 3, 8'sd54, 32'd100, 32'd1, 32'd0, 1'b0));
    send(make_item(FUNC_SET, 63, 8'sd69, 32'h7FFF_FFFF, 32'd2, 32'd3, 1'b1));
    send(make_item(FUNC_SET, 4, 8'sd70, 32'd5, 32'd1, 32'd1, 1'b0));
    send(make_item(FUNC_SET, 5, -8'sd1, 32'd1, 32'd1, 32'd0, 1'b0));
    send(make_item(FUNC_SET, 6, -8'sd128, 32'h8000_0000, 32'd1, 32'd1, 1'b1));
    send(make_item(FUNC_SET, 7, 8'sd127, 32'd1, 32'd0, 32'd0, 1'b0));
    send(make_item(FUNC_SET, 8'd64, 8'sd54, 32'd7, 32'd1, 32'd1, 1'b0));
    send(make_item(FUNC_SET, 8'd255, 8'sd1, 32'd1, 32'd1, 32'd1, 1'b0));
    send(make_item(FUNC_UNUSED, 8'hFF, 8'sd127, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                   32'hFFFF_FFFF, 1'b1));
    repeat (6) send(make_item(FUNC_TICK, 0, 0, 0, 0, 0, 0));
    send(make_item(FUNC_SET, 8, 8'sd60, -32'sd5, 32'd1, 32'd1, 1'b0));
    send(make_item(FUNC_SET, 9, 8'sd20, 32'd1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0));
    send(make_item(FUNC_TICK, 0, 0, 0, 0, 0, 0));
    send(make_item(FUNC_CLEAR, 0, 0, 0, 0, 0, 0));
    send(make_item(FUNC_TICK, 0, 0, 0, 0, 0, 0));
    wait_drained();

    while (items_sent < TOTAL_ITEMS) begin
      if (!mid_pause_done && items_sent >= TOTAL_ITEMS / 2) begin
        wait_drained();
        mid_pause_done = 1'b1;
      end
      if ($urandom_range(0, 4) == 0) repeat ($urandom_range(1, 3)) noise_item();
      else run_pattern();
    end
    push <= 1'b0;

    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);

    $display("covered %0d transactions (%0d ticks) with all pin classes and one-shot mode",
             items_sent, ticks_sent);
    $display("checked %0d drive changes, %0d of them analog", checked, analog_seen);
    if (fail_count == 0 && pending == 0) begin
      $display("multi_channel_pulse_modulator_top regression: pass");
    end else begin
      $display("multi_channel_pulse_modulator_top regression: fail");
    end
    $finish;
  end

endmodule

FILE: sim.f
hw/rtl/mcpm_pkg.sv
hw/rtl/mcpm_ram.sv
hw/rtl/mcpm_fifo.sv
hw/rtl/mcpm_front.sv
hw/rtl/mcpm_back.sv
hw/rtl/multi_channel_pulse_modulator_top.sv
tb/mcpm_drive_checker.sv
tb/tb_multi_channel_pulse_modulator_top.sv
